FILE: design/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; every macro samples on the rising edge of clock and skips reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/cln_pkg.sv
// shared types and constants of the config line normalizer
// no dependencies; used by the controller, datapath and top level
`default_nettype none

package cln_pkg;

   localparam int LINE_DEPTH_DEFAULT = 32;

   // configuration register indexes
   localparam logic CSR_MAX_LINE_LENGTH = 1'b0;
   localparam logic CSR_MAX_LINES       = 1'b1;

   localparam logic [5:0] MAX_LINE_LENGTH_RESET = 6'd32;
   localparam logic [7:0] MAX_LINES_RESET       = 8'd255;
   localparam logic [7:0] LINES_SATURATE        = 8'd255;

   // line status codes
   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_END     = 2'd2;

   // request types
   localparam logic REQ_DATA    = 1'b0;
   localparam logic REQ_RESTART = 1'b1;

   // character codes
   localparam logic [7:0] CHAR_NUL     = 8'd0;
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_HYPHEN  = 8'd45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;

   // controller state, one-hot
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CHAR = 4'b0010,
      S_READ = 4'b0100,
      S_LOAD = 4'b1000
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       clear_all;
      logic       clear_line;
      logic       byte_step;
      logic       char_step;
      logic       count_line;
      logic       emit_start;
      logic       emit_next;
      logic       load_status;
      logic [1:0] status_code;
      logic       load_empty;
      logic       load_char;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic restart;
      logic ended;
      logic limit_hit;
      logic is_zero;
      logic is_newline;
      logic line_bad;
      logic line_empty;
      logic cut;
      logic need_space;
      logic out_free;
      logic emit_last;
   } stat_type;

endpackage

`default_nettype wire

FILE: design/cln_if.sv
// valid/ready channel interfaces for request bytes and result items
// depends on nothing but the fixed field widths
`default_nettype none

interface cln_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface cln_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       char_present;
   logic       last_of_line;
   logic [1:0] line_status;

   modport source (output valid, output out_char, output char_present,
                   output last_of_line, output line_status, input ready);
   modport sink (input valid, input out_char, input char_present,
                 input last_of_line, input line_status, output ready);
endinterface

`default_nettype wire

FILE: design/config_line_normalizer.sv
// config line normalizer: a byte with a space due is stored after the space, in S_CHAR
// a status result shows in the cycle after its byte; after the newline each character
// of a good line is registered out of the line store in S_READ, then loaded in S_LOAD
// a new byte is taken only while no line is being emitted and the output register is free
// reset is synchronous: control state cleared, registers to 32 and 255, no clearing pass
`default_nettype none

module config_line_normalizer #(
   parameter int LINE_DEPTH = cln_pkg::LINE_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cln_req_if.sink    req_ch,
   cln_rsp_if.source  rsp_ch,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   // command and status between controller and datapath
   cln_pkg::cmd_type  cmd;
   cln_pkg::stat_type stat;

   // controller owns the request handshake and line sequencing
   cln_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath holds the config, the line store and the result register
   cln_datapath #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_type         (req_ch.req_type),
      .data_byte        (req_ch.data_byte),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_out_char     (rsp_ch.out_char),
      .rsp_char_present (rsp_ch.char_present),
      .rsp_last_of_line (rsp_ch.last_of_line),
      .rsp_line_status  (rsp_ch.line_status),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

`default_nettype wire

FILE: design/cln_ctrl.sv
// controller state machine of the config line normalizer
// depends on cln_pkg for the state, command and status types
`default_nettype none

module cln_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire cln_pkg::stat_type  stat,
   output cln_pkg::cmd_type        cmd
);

   cln_pkg::state_type state_ff, state_in;
   logic               accept;

   assign req_ready = (state_ff == cln_pkg::S_IDLE) && stat.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         cln_pkg::S_IDLE: begin
            if (accept) begin
               priority if (stat.restart) begin
                  cmd.clear_all = 1'b1;
               end else if (stat.ended) begin
                  // stream over, byte dropped
               end else if (stat.limit_hit) begin
                  cmd.load_status = 1'b1;
                  cmd.status_code = cln_pkg::STATUS_INVALID;
               end else if (stat.is_zero) begin
                  cmd.load_status = 1'b1;
                  cmd.status_code = cln_pkg::STATUS_END;
               end else if (stat.is_newline) begin
                  if (stat.line_bad) begin
                     cmd.load_status = 1'b1;
                     cmd.status_code = cln_pkg::STATUS_INVALID;
                  end else if (stat.line_empty) begin
                     cmd.load_empty = 1'b1;
                     cmd.count_line = 1'b1;
                     cmd.clear_line = 1'b1;
                  end else begin
                     cmd.count_line = 1'b1;
                     cmd.emit_start = 1'b1;
                     state_in       = cln_pkg::S_READ;
                  end
               end else if (stat.cut) begin
                  cmd.load_status = 1'b1;
                  cmd.status_code = cln_pkg::STATUS_INVALID;
               end else begin
                  cmd.byte_step = 1'b1;
                  if (stat.need_space) begin
                     state_in = cln_pkg::S_CHAR;
                  end
               end
            end
         end
         cln_pkg::S_CHAR: begin
            cmd.char_step = 1'b1;
            state_in      = cln_pkg::S_IDLE;
         end
         cln_pkg::S_READ: begin
            state_in = cln_pkg::S_LOAD;
         end
         cln_pkg::S_LOAD: begin
            if (stat.out_free) begin
               cmd.load_char = 1'b1;
               if (stat.emit_last) begin
                  cmd.clear_line = 1'b1;
                  state_in       = cln_pkg::S_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = cln_pkg::S_READ;
               end
            end
         end
         default: begin
            state_in = cln_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cln_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/cln_datapath.sv
// datapath: config registers, line store memory, line counters and output register
// depends on cln_pkg for command/status types and constants
`default_nettype none

module cln_datapath #(
   parameter int LINE_DEPTH = cln_pkg::LINE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [7:0]         csr_wdata,
   input  wire logic               req_type,
   input  wire logic [7:0]         data_byte,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [6:0]              rsp_out_char,
   output logic                    rsp_char_present,
   output logic                    rsp_last_of_line,
   output logic [1:0]              rsp_line_status,
   input  wire cln_pkg::cmd_type   cmd,
   output cln_pkg::stat_type       stat
);

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int CW = $clog2(LINE_DEPTH + 1);
   localparam int RW = $clog2(LINE_DEPTH + 3);
   localparam int LW = ((RW > 6) ? RW : 6) + 1;

   logic [5:0]    max_len_ff;
   logic [7:0]    max_lines_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [RW-1:0] raw_ff, raw_in;
   logic          pending_ff, pending_in;
   logic          bad_ff, bad_in;
   logic [7:0]    lines_ff, lines_in;
   logic          ended_ff, ended_in;
   logic [6:0]    held_ff;
   logic [AW-1:0] emit_idx_ff, emit_idx_in;
   logic [6:0]    rd_ff;
   logic [6:0]    mem [LINE_DEPTH];

   logic          out_valid_ff, out_valid_in;
   logic [6:0]    out_char_ff, out_char_in;
   logic          out_present_ff, out_present_in;
   logic          out_last_ff, out_last_in;
   logic [1:0]    out_status_ff, out_status_in;

   logic          is_ws, is_lower, is_upper, is_good;
   logic [6:0]    lowered;
   logic          room;
   logic          wr_en;
   logic [6:0]    wr_data;
   logic [LW-1:0] limit;
   logic          out_load;

   // byte classes
   assign is_ws    = (data_byte == cln_pkg::CHAR_SPACE) || (data_byte == cln_pkg::CHAR_TAB);
   assign is_lower = ((data_byte >= cln_pkg::CHAR_ZERO) && (data_byte <= cln_pkg::CHAR_NINE))
                   || ((data_byte >= cln_pkg::CHAR_LOWER_A)
                       && (data_byte <= cln_pkg::CHAR_LOWER_Z))
                   || (data_byte == cln_pkg::CHAR_HYPHEN);
   assign is_upper = (data_byte >= cln_pkg::CHAR_UPPER_A) && (data_byte <= cln_pkg::CHAR_UPPER_Z);
   assign is_good  = is_lower || is_upper;

   always_comb begin
      logic [7:0] sum;
      sum     = data_byte + cln_pkg::CASE_OFFSET;
      lowered = is_upper ? sum[6:0] : data_byte[6:0];
   end

   assign room  = count_ff < CW'(LINE_DEPTH);
   assign limit = (LW'(max_len_ff) > LW'(LINE_DEPTH)) ? LW'(LINE_DEPTH) : LW'(max_len_ff);

   assign stat.restart    = (req_type == cln_pkg::REQ_RESTART);
   assign stat.ended      = ended_ff;
   assign stat.limit_hit  = (raw_ff == '0) && (lines_ff >= max_lines_ff);
   assign stat.is_zero    = (data_byte == cln_pkg::CHAR_NUL);
   assign stat.is_newline = (data_byte == cln_pkg::CHAR_NEWLINE);
   assign stat.line_bad   = (LW'(raw_ff) > limit) || bad_ff;
   assign stat.line_empty = (count_ff == '0);
   assign stat.cut        = raw_ff >= RW'(LINE_DEPTH + 1);
   assign stat.need_space = is_good && pending_ff;
   assign stat.out_free   = !out_valid_ff || rsp_ready;
   assign stat.emit_last  = (CW'(emit_idx_ff) + CW'(1)) == count_ff;

   // line state
   always_comb begin
      count_in    = count_ff;
      raw_in      = raw_ff;
      pending_in  = pending_ff;
      bad_in      = bad_ff;
      lines_in    = lines_ff;
      ended_in    = ended_ff;
      emit_idx_in = emit_idx_ff;
      wr_en       = 1'b0;
      wr_data     = lowered;

      if (cmd.byte_step) begin
         raw_in = raw_ff + RW'(1);
         if (is_ws) begin
            pending_in = pending_ff || (count_ff != '0);
         end else if (is_good) begin
            pending_in = 1'b0;
            wr_en      = room;
            wr_data    = pending_ff ? cln_pkg::CHAR_SPACE[6:0] : lowered;
         end else begin
            bad_in = 1'b1;
         end
      end
      if (cmd.char_step) begin
         wr_en   = room;
         wr_data = held_ff;
      end
      if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.count_line && (lines_ff != cln_pkg::LINES_SATURATE)) begin
         lines_in = lines_ff + 8'd1;
      end
      if (cmd.emit_start) begin
         emit_idx_in = '0;
      end
      if (cmd.emit_next) begin
         emit_idx_in = emit_idx_ff + AW'(1);
      end
      if (cmd.load_status) begin
         ended_in = 1'b1;
      end
      if (cmd.clear_line || cmd.load_status || cmd.clear_all) begin
         count_in   = '0;
         raw_in     = '0;
         pending_in = 1'b0;
         bad_in     = 1'b0;
      end
      if (cmd.clear_all) begin
         lines_in = '0;
         ended_in = 1'b0;
      end
   end

   // output register
   assign out_load = cmd.load_status || cmd.load_empty || cmd.load_char;

   always_comb begin
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_char_in    = out_char_ff;
      out_present_in = out_present_ff;
      out_last_in    = out_last_ff;
      out_status_in  = out_status_ff;
      if (out_load) begin
         out_valid_in   = 1'b1;
         out_char_in    = cmd.load_char ? rd_ff : 7'd0;
         out_present_in = cmd.load_char;
         out_last_in    = cmd.load_char ? stat.emit_last : 1'b1;
         out_status_in  = cmd.load_status ? cmd.status_code : cln_pkg::STATUS_GOOD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= cln_pkg::MAX_LINE_LENGTH_RESET;
         max_lines_ff <= cln_pkg::MAX_LINES_RESET;
         count_ff     <= '0;
         raw_ff       <= '0;
         pending_ff   <= 1'b0;
         bad_ff       <= 1'b0;
         lines_ff     <= '0;
         ended_ff     <= 1'b0;
         emit_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               cln_pkg::CSR_MAX_LINE_LENGTH: max_len_ff   <= csr_wdata[5:0];
               cln_pkg::CSR_MAX_LINES:       max_lines_ff <= csr_wdata;
               default: ;
            endcase
         end
         count_ff     <= count_in;
         raw_ff       <= raw_in;
         pending_ff   <= pending_in;
         bad_ff       <= bad_in;
         lines_ff     <= lines_in;
         ended_ff     <= ended_in;
         emit_idx_ff  <= emit_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_step) begin
         held_ff <= lowered;
      end
      out_char_ff    <= out_char_in;
      out_present_ff <= out_present_in;
      out_last_ff    <= out_last_in;
      out_status_ff  <= out_status_in;
   end

   // line store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= wr_data;
      end
      rd_ff <= mem[emit_idx_ff];
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_char     = out_char_ff;
   assign rsp_char_present = out_present_ff;
   assign rsp_last_of_line = out_last_ff;
   assign rsp_line_status  = out_status_ff;

endmodule

`default_nettype wire

FILE: design/cln_checker.sv
// port-level checks of the config line normalizer result channel, bound to the top level
// depends on assert_macros.svh, cln_pkg and config_line_normalizer
`default_nettype none
`include "assert_macros.svh"

module cln_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [6:0] rsp_out_char,
   input wire logic       rsp_char_present,
   input wire logic       rsp_last_of_line,
   input wire logic [1:0] rsp_line_status
);

   logic [10:0] rsp_payload;
   logic        rsp_stall;
   logic        status_item;
   logic        status_known;
   logic        char_known;
   logic        status_ok;
   logic        empty_ok;
   logic        char_ok;

   assign rsp_payload  = {rsp_out_char, rsp_char_present, rsp_last_of_line, rsp_line_status};
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign status_item  = (rsp_line_status != cln_pkg::STATUS_GOOD);
   assign status_known = (rsp_line_status == cln_pkg::STATUS_GOOD)
                       || (rsp_line_status == cln_pkg::STATUS_INVALID)
                       || (rsp_line_status == cln_pkg::STATUS_END);
   assign char_known   = (rsp_out_char == cln_pkg::CHAR_SPACE[6:0])
                       || (rsp_out_char == cln_pkg::CHAR_HYPHEN[6:0])
                       || ((rsp_out_char >= cln_pkg::CHAR_ZERO[6:0])
                           && (rsp_out_char <= cln_pkg::CHAR_NINE[6:0]))
                       || ((rsp_out_char >= cln_pkg::CHAR_LOWER_A[6:0])
                           && (rsp_out_char <= cln_pkg::CHAR_LOWER_Z[6:0]));
   assign status_ok    = !rsp_char_present && rsp_last_of_line && (rsp_out_char == 7'd0);
   assign empty_ok     = rsp_last_of_line && (rsp_out_char == 7'd0) && status_known;
   assign char_ok      = (rsp_line_status == cln_pkg::STATUS_GOOD) && char_known;

   // a stalled item holds
   `ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled item changed")

   // status items carry no character and close the run
   `ASSERT_IMPL(a_status_shape, rsp_valid && status_item, status_ok, "status item malformed")

   // an item without character is the empty line or a status, always last
   `ASSERT_IMPL(a_empty_shape, rsp_valid && !rsp_char_present, empty_ok, "empty item malformed")

   // emitted characters are normalized: space, digit, lower-case letter or hyphen
   `ASSERT_IMPL(a_char_class, rsp_valid && rsp_char_present, char_ok, "character not normalized")

endmodule

bind config_line_normalizer cln_checker u_cln_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_out_char     (rsp_ch.out_char),
   .rsp_char_present (rsp_ch.char_present),
   .rsp_last_of_line (rsp_ch.last_of_line),
   .rsp_line_status  (rsp_ch.line_status)
);

`default_nettype wire

FILE: tb/testbench.sv
// self-checking bench for config_line_normalizer: byte stream in, normalized line items out
// depends on cln_pkg and the cln_req_if / cln_rsp_if channel interfaces
`timescale 1ns / 1ps

module testbench;

   localparam int DEPTH         = cln_pkg::LINE_DEPTH_DEFAULT;
   localparam int CUT_BYTES     = DEPTH + 2;
   // settle well past the time a line of DEPTH characters takes to drain
   localparam int SETTLE_CYCLES = 4 * DEPTH;
   // longest receiver hold-off, counted in the pacing process
   localparam int HOLD_CYCLES   = 400;
   // cycles with no item moving on either channel before the run is called hung
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 60;
   localparam int NUM_PHASES    = 8;

   // one result item as it leaves the block
   typedef struct packed {
      logic [6:0] out_char;
      logic       char_present;
      logic       last_of_line;
      logic [1:0] line_status;
   } out_item_type;

   // line normalizer prediction plus the queue of result items still due
   class line_tracker;
      out_item_type due_q[$];
      logic [6:0]   line_chars [DEPTH];
      int unsigned  char_count;
      int unsigned  raw_count;
      bit           space_due;
      bit           bad_seen;
      bit           stream_over;
      logic [7:0]   good_lines;
      logic [5:0]   len_limit;
      logic [7:0]   line_cap;
      int unsigned  errors;
      int unsigned  checked;

      function new();
         len_limit = cln_pkg::MAX_LINE_LENGTH_RESET;
         line_cap  = cln_pkg::MAX_LINES_RESET;
         errors    = 0;
         checked   = 0;
         restart_file();
      endfunction

      function void clear_line();
         char_count = 0;
         raw_count  = 0;
         space_due  = 1'b0;
         bad_seen   = 1'b0;
      endfunction

      function void restart_file();
         clear_line();
         good_lines  = '0;
         stream_over = 1'b0;
      endfunction

      static function bit is_blank(logic [7:0] b);
         return (b == cln_pkg::CHAR_SPACE) || (b == cln_pkg::CHAR_TAB);
      endfunction

      static function bit is_upper(logic [7:0] b);
         return (b >= cln_pkg::CHAR_UPPER_A) && (b <= cln_pkg::CHAR_UPPER_Z);
      endfunction

      static function bit is_word(logic [7:0] b);
         return ((b >= cln_pkg::CHAR_ZERO) && (b <= cln_pkg::CHAR_NINE)) ||
                ((b >= cln_pkg::CHAR_LOWER_A) && (b <= cln_pkg::CHAR_LOWER_Z)) ||
                (b == cln_pkg::CHAR_HYPHEN) || is_upper(b);
      endfunction

      function int unsigned due_count();
         return due_q.size();
      endfunction

      function void set_reg(logic idx, logic [7:0] val);
         if (idx == cln_pkg::CSR_MAX_LINE_LENGTH) begin
            len_limit = val[5:0];
         end else begin
            line_cap = val;
         end
      endfunction

      function void push_status(logic [1:0] code);
         out_item_type r;
         r.out_char     = '0;
         r.char_present = 1'b0;
         r.last_of_line = 1'b1;
         r.line_status  = code;
         due_q.push_back(r);
         stream_over = 1'b1;
         clear_line();
      endfunction

      function void add_char(logic [7:0] c);
         if (char_count < DEPTH) begin
            line_chars[char_count] = c[6:0];
            char_count++;
         end
      endfunction

      function void take_byte(logic kind, logic [7:0] b);
         out_item_type r;
         int unsigned  lim;
         logic [7:0]   lc;
         if (kind == cln_pkg::REQ_RESTART) begin
            restart_file();
            return;
         end
         if (stream_over) return;
         if (raw_count == 0 && good_lines >= line_cap) begin
            push_status(cln_pkg::STATUS_INVALID);
            return;
         end
         if (b == cln_pkg::CHAR_NUL) begin
            push_status(cln_pkg::STATUS_END);
            return;
         end
         if (b == cln_pkg::CHAR_NEWLINE) begin
            lim = (len_limit > DEPTH) ? DEPTH : len_limit;
            if (raw_count > lim || bad_seen) begin
               push_status(cln_pkg::STATUS_INVALID);
               return;
            end
            if (char_count == 0) begin
               r.out_char     = '0;
               r.char_present = 1'b0;
               r.last_of_line = 1'b1;
               r.line_status  = cln_pkg::STATUS_GOOD;
               due_q.push_back(r);
            end else begin
               for (int k = 0; k < char_count; k++) begin
                  r.out_char     = line_chars[k];
                  r.char_present = 1'b1;
                  r.last_of_line = (k + 1 == char_count);
                  r.line_status  = cln_pkg::STATUS_GOOD;
                  due_q.push_back(r);
               end
            end
            if (good_lines != cln_pkg::LINES_SATURATE) good_lines++;
            clear_line();
            return;
         end
         raw_count++;
         if (is_blank(b)) begin
            if (char_count > 0) space_due = 1'b1;
         end else if (is_word(b)) begin
            if (space_due) add_char(cln_pkg::CHAR_SPACE);
            space_due = 1'b0;
            lc = is_upper(b) ? b + cln_pkg::CASE_OFFSET : b;
            add_char(lc);
         end else begin
            bad_seen = 1'b1;
         end
         if (raw_count >= CUT_BYTES) push_status(cln_pkg::STATUS_INVALID);
      endfunction

      function void match_output(out_item_type got);
         out_item_type want;
         checked++;
         if (due_q.size() == 0) begin
            $error("result with nothing due: char %0d present %0d last %0d status %0d",
                   got.out_char, got.char_present, got.last_of_line, got.line_status);
            errors++;
            return;
         end
         want = due_q.pop_front();
         if (got.out_char !== want.out_char) begin
            $error("out_char: expected %0d, actual %0d", want.out_char, got.out_char);
            errors++;
         end
         if (got.char_present !== want.char_present) begin
            $error("char_present: expected %0d, actual %0d",
                   want.char_present, got.char_present);
            errors++;
         end
         if (got.last_of_line !== want.last_of_line) begin
            $error("last_of_line: expected %0d, actual %0d",
                   want.last_of_line, got.last_of_line);
            errors++;
         end
         if (got.line_status !== want.line_status) begin
            $error("line_status: expected %0d, actual %0d",
                   want.line_status, got.line_status);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   cln_req_if req_bus ();
   cln_rsp_if rsp_bus ();

   config_line_normalizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   line_tracker sb = new();

   // pacing controls shared by the sender, the receiver and the main sequence
   bit          hold_req = 1'b0;   // ask the receiver for one long hold-off
   bit          steady   = 1'b0;   // no idling on either side
   int unsigned live_items = 0; // items the block acts on (ignored bytes not counted)
   int unsigned settings_used = 1;
   int unsigned quiet_cycles = 0;

   // register settings per random phase: extremes first, last one drawn at run time
   logic [5:0] phase_len [NUM_PHASES] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd8, 6'd20, 6'd32, 6'd5};
   logic [7:0] phase_cap [NUM_PHASES] = '{8'd255, 8'd3, 8'd2, 8'd255, 8'd0, 8'd1, 8'd255, 8'd9};

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver pacing: ready changes on the falling edge only
   initial begin : rsp_pacing
      int unsigned hold_left;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            // long stall so the block backs up into its input
            rsp_bus.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            while (hold_left != 0) begin
               @(negedge clock);
               hold_left--;
            end
            hold_req = 1'b0;
         end else if (steady) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= 20);
         end
      end
   end

   // every accepted result is checked against the oldest one due
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.match_output('{rsp_bus.out_char, rsp_bus.char_present,
                           rsp_bus.last_of_line, rsp_bus.line_status});
      end
   end

   // hang detection: nothing moving on either channel for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $error("no item moved for %0d cycles, %0d results still due",
                QUIET_LIMIT, sb.due_count());
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one item, at times after a random gap, and wait for the handshake
   task automatic send_item(input logic kind, input logic [7:0] b);
      int unsigned gap;
      if (!steady && $urandom_range(0, 99) < 20) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= kind;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      // bytes after the end of a stream are ignored and not counted
      if (kind == cln_pkg::REQ_RESTART || !sb.stream_over) live_items++;
      sb.take_byte(kind, b);
   endtask

   // stop offering, wait for every result due, then let the block settle
   task automatic wait_results_done();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.due_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers back to back; upper bits of the length write are junk
   task automatic write_regs(input logic [5:0] len, input logic [7:0] cap);
      logic [1:0] junk;
      logic [7:0] wd;
      junk = 2'($urandom_range(0, 3));
      wd = {junk, len};
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= cln_pkg::CSR_MAX_LINE_LENGTH;
      csr_wdata <= wd;
      @(posedge clock);
      sb.set_reg(cln_pkg::CSR_MAX_LINE_LENGTH, wd);
      @(negedge clock);
      csr_index <= cln_pkg::CSR_MAX_LINES;
      csr_wdata <= cap;
      @(posedge clock);
      sb.set_reg(cln_pkg::CSR_MAX_LINES, cap);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // a byte outside the allowed set, never newline or zero
   function automatic logic [7:0] bad_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (line_tracker::is_word(b) || line_tracker::is_blank(b)
             || b == cln_pkg::CHAR_NEWLINE);
      return b;
   endfunction

   // a legal line byte, mixed case letters mostly
   function automatic logic [7:0] line_char();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30) return 8'($urandom_range(cln_pkg::CHAR_LOWER_A, cln_pkg::CHAR_LOWER_Z));
      if (r < 60) return 8'($urandom_range(cln_pkg::CHAR_UPPER_A, cln_pkg::CHAR_UPPER_Z));
      if (r < 75) return 8'($urandom_range(cln_pkg::CHAR_ZERO, cln_pkg::CHAR_NINE));
      if (r < 80) return cln_pkg::CHAR_HYPHEN;
      if (r < 92) return cln_pkg::CHAR_SPACE;
      return cln_pkg::CHAR_TAB;
   endfunction

   // one line: mostly within the limit, some too long, a few cut for lack of newline
   task automatic send_line();
      int unsigned lim;
      int unsigned n;
      int unsigned shape;
      int unsigned term;
      int          bad_pos;
      logic [7:0]  b;
      lim   = (sb.len_limit > DEPTH) ? DEPTH : sb.len_limit;
      shape = $urandom_range(0, 99);
      if (shape < 80) n = $urandom_range(0, lim);
      else if (shape < 93) n = lim + 1 + $urandom_range(0, 2);
      else n = $urandom_range(CUT_BYTES, CUT_BYTES + 4);
      bad_pos = -1;
      if (n > 0 && $urandom_range(0, 99) < 5) bad_pos = int'($urandom_range(0, n - 1));
      for (int i = 0; i < n; i++) begin
         if (sb.stream_over) break;
         if (i == bad_pos) b = bad_byte();
         else if ($urandom_range(0, 99) < 3) b = 8'($urandom_range(0, 255));
         else b = line_char();
         send_item(cln_pkg::REQ_DATA, b);
      end
      // cut lines end on their own, the rest get a terminator
      if (!sb.stream_over && shape < 93) begin
         term = $urandom_range(0, 99);
         if (term < 90) send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_NEWLINE);
         else if (term < 95) send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_NUL);
         else send_item(cln_pkg::REQ_RESTART, 8'($urandom_range(0, 255)));
      end
   endtask

   // random stream: lines while the stream is open, mostly restarts once it ended
   task automatic random_items(input int unsigned count);
      int unsigned target;
      target = live_items + count;
      while (live_items < target) begin
         if (sb.stream_over) begin
            if ($urandom_range(0, 99) < 90) begin
               send_item(cln_pkg::REQ_RESTART, 8'($urandom_range(0, 255)));
            end else begin
               send_item(cln_pkg::REQ_DATA, 8'($urandom_range(0, 255)));
            end
         end else begin
            send_line();
         end
      end
   endtask

   initial begin
      // all inputs known from time zero
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.req_type  = cln_pkg::REQ_DATA;
      req_bus.data_byte = '0;
      csr_we            = 1'b0;
      csr_index         = cln_pkg::CSR_MAX_LINE_LENGTH;
      csr_wdata         = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening at the reset settings
      // restart with every data bit set
      send_item(cln_pkg::REQ_RESTART, 8'hFF);
      // leading blank, tab plus space run, trailing blank, case folding, digit, hyphen
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_SPACE);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_UPPER_A);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_TAB);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_SPACE);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_LOWER_Z);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_HYPHEN);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_NINE);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_SPACE);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_NEWLINE);
      // empty line
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_NEWLINE);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_ZERO);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_UPPER_Z);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_NEWLINE);
      // whitespace only line comes out empty
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_TAB);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_NEWLINE);
      // disallowed byte fails at the newline and ends the stream
      send_item(cln_pkg::REQ_DATA, 8'hFF);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_NEWLINE);
      // ignored after the end
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_LOWER_A);
      // zero byte ends the stream normally, dropping the open line
      send_item(cln_pkg::REQ_RESTART, 8'h00);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_LOWER_A + 8'd1);
      send_item(cln_pkg::REQ_DATA, cln_pkg::CHAR_NUL);
      send_item(cln_pkg::REQ_RESTART, 8'h00);

      // random phases, one register setting each
      phase_len[NUM_PHASES-1] = 6'($urandom_range(1, DEPTH));
      phase_cap[NUM_PHASES-1] = 8'($urandom_range(0, 255));
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_results_done();
         write_regs(phase_len[p], phase_cap[p]);
         steady = (p == 6);
         send_item(cln_pkg::REQ_RESTART, 8'($urandom_range(0, 255)));
         if (p == 1) begin
            // sender pauses mid-phase until the block has drained
            random_items(PHASE_ITEMS / 2);
            wait_results_done();
            random_items(PHASE_ITEMS / 2);
         end else begin
            // in phase 3 the receiver stalls while lines keep coming, filling the block
            if (p == 3) hold_req = 1'b1;
            random_items(PHASE_ITEMS);
         end
      end
      steady = 1'b0;

      wait_results_done();
      $display("covered %0d live items and %0d result items under %0d register settings",
               live_items, sb.checked, settings_used);
      if (sb.errors == 0 && sb.due_count() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
